// ----- src/edf_pkg.sv -----
// Shared types and field widths for the EDF tick scheduler.
// No dependencies.
`default_nettype none

package edf_pkg;

  localparam int unsigned WorkW  = 16;
  localparam int unsigned DlW    = 32;
  localparam int unsigned TaskIw = 4;
  localparam int unsigned MissW  = 16;
  localparam int unsigned CntW   = 5;

  typedef struct packed {
    logic [15:0] rel_deadline;
    logic [15:0] period;
    logic [15:0] exec_time;
  } task_cfg_t;

  typedef struct packed {
    logic [15:0]      phase;
    logic [DlW-1:0]   abs_dl;
    logic [WorkW-1:0] work;
  } task_run_t;

endpackage

`default_nettype wire

// ----- src/edf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module edf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/edf_tick_scheduler_top.sv -----
// EDF tick scheduler top level: sequencer, per-slot scan unit, output register.
// Depends on edf_pkg and edf_ram.
// A load beat is taken while idle. A tick beat scans all MAX_TASKS slots, one per
// cycle through the single read port of the slot RAMs, then the result register is
// loaded as the sequencer returns to idle for the next beat; a held result stalls the last step.
// Reset clears time, task count and all slot state via per-slot valid flags; no clear pass.
`default_nettype none

module edf_tick_scheduler_top
  import edf_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CntW-1:0]  cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_index[3:0], exec_time[19:4], period[35:20], rel_deadline[51:36], zero pad
  input  wire logic [55:0]      s_axis_tdata,
  // kind[0]
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // time_now[31:0], running_task[35:32], running_deadline[67:36], miss_mask[83:68]
  output logic [87:0]           m_axis_tdata,
  // idle[0]
  output logic                  m_axis_tuser
);

  localparam int unsigned IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  localparam logic KIND_LOAD = 1'b0;

  logic [1:0]           state_q, state_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic [TIME_BITS-1:0] t_q, t_d;
  logic [CntW-1:0]      task_count_q;
  logic [MAX_TASKS-1:0] cfg_vld_q, cfg_vld_d;
  logic [MAX_TASKS-1:0] run_vld_q, run_vld_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [DlW-1:0]       best_abs_q, best_abs_d;
  logic [WorkW-1:0]     best_work_q, best_work_d;
  logic [15:0]          best_phase_q, best_phase_d;
  logic [MissW-1:0]     miss_q, miss_d;

  logic                 out_vld_q;
  logic [31:0]          out_time_q;
  logic                 out_idle_q;
  logic [TaskIw-1:0]    out_task_q;
  logic [DlW-1:0]       out_dl_q;
  logic [MissW-1:0]     out_miss_q;

  logic                 in_fire, out_free, fix_done, proc;
  logic [CNTW-1:0]      cnt_m1;
  logic [IW-1:0]        pi, rd_addr, ld_addr, run_waddr;
  logic [31:0]          pi32, ti32, t32;
  logic [TIME_BITS-1:0] t_next;
  logic                 ld_ok, rel, act;
  task_cfg_t            ld_cfg, cfg_rd, c_cfg;
  task_run_t            run_rd, c_run, run_new, run_wdata;
  logic                 run_we;
  logic [16:0]          phase_inc;
  logic [15:0]          phase_next;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign fix_done = (state_q == ST_FIX) && out_free;
  assign proc     = (state_q == ST_SCAN) && (cnt_q != '0);

  assign cnt_m1  = cnt_q - CNTW'(1);
  assign pi      = cnt_m1[IW-1:0];
  assign pi32    = 32'(pi);
  assign act     = pi32 < 32'(task_count_q);
  assign rd_addr = (cnt_q < CNTW'(MAX_TASKS)) ? cnt_q[IW-1:0] : '0;
  assign ti32    = 32'(s_axis_tdata[3:0]);
  assign ld_addr = ti32[IW-1:0];
  assign ld_ok   = ti32 < 32'(MAX_TASKS);
  assign t32     = 32'(t_q);
  assign t_next  = t_q + TIME_BITS'(1);

  assign ld_cfg.exec_time    = s_axis_tdata[19:4];
  assign ld_cfg.period       = s_axis_tdata[35:20];
  assign ld_cfg.rel_deadline = s_axis_tdata[51:36];

  edf_ram #(.WIDTH($bits(task_cfg_t)), .DEPTH(MAX_TASKS)) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (s_axis_tuser == KIND_LOAD) && ld_ok),
    .waddr_i (ld_addr),
    .wdata_i (ld_cfg),
    .raddr_i (rd_addr),
    .rdata_o (cfg_rd)
  );

  edf_ram #(.WIDTH($bits(task_run_t)), .DEPTH(MAX_TASKS)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i (rd_addr),
    .rdata_o (run_rd)
  );

  // per-slot release check, phase step and next run state
  always_comb begin
    c_cfg = cfg_vld_q[pi] ? cfg_rd : '0;
    c_run = run_vld_q[pi] ? run_rd : '0;
    rel   = act && (c_cfg.period != '0) && (c_run.phase == '0);
    phase_inc = {1'b0, c_run.phase} + 17'd1;
    if ((t_next == '0) || (c_cfg.period == '0)) begin
      phase_next = '0;
    end else if (phase_inc >= {1'b0, c_cfg.period}) begin
      phase_next = '0;
    end else begin
      phase_next = phase_inc[15:0];
    end
    run_new.phase  = phase_next;
    run_new.work   = rel ? c_cfg.exec_time : c_run.work;
    run_new.abs_dl = rel ? (t32 + {16'b0, c_cfg.rel_deadline}) : c_run.abs_dl;
  end

  always_comb begin
    run_we    = 1'b0;
    run_waddr = pi;
    run_wdata = run_new;
    if (proc) begin
      run_we = 1'b1;
    end else if (fix_done && found_q) begin
      run_we           = 1'b1;
      run_waddr        = pick_q;
      run_wdata.phase  = best_phase_q;
      run_wdata.abs_dl = best_abs_q;
      run_wdata.work   = best_work_q - WorkW'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    t_d          = t_q;
    cfg_vld_d    = cfg_vld_q;
    run_vld_d    = run_vld_q;
    found_d      = found_q;
    pick_d       = pick_q;
    best_abs_d   = best_abs_q;
    best_work_d  = best_work_q;
    best_phase_d = best_phase_q;
    miss_d       = miss_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == KIND_LOAD) begin
            if (ld_ok) begin
              cfg_vld_d[ld_addr] = 1'b1;
            end
            run_vld_d = '0;
            t_d       = '0;
          end else begin
            state_d = ST_SCAN;
            cnt_d   = '0;
            found_d = 1'b0;
            miss_d  = '0;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNTW'(1);
        if (proc) begin
          run_vld_d[pi] = 1'b1;
          if (rel && (c_run.work != '0) && (t_q != '0) && (pi32 < 32'(MissW))) begin
            miss_d[pi32[3:0]] = 1'b1;
          end
          if (act && (run_new.work != '0) &&
              (!found_q || (run_new.abs_dl < best_abs_q))) begin
            found_d      = 1'b1;
            pick_d       = pi;
            best_abs_d   = run_new.abs_dl;
            best_work_d  = run_new.work;
            best_phase_d = run_new.phase;
          end
          if (cnt_q == CNTW'(MAX_TASKS)) begin
            state_d = ST_FIX;
          end
        end
      end
      ST_FIX: begin
        if (out_free) begin
          state_d = ST_IDLE;
          t_d     = t_next;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      t_q          <= '0;
      task_count_q <= '0;
      cfg_vld_q    <= '0;
      run_vld_q    <= '0;
      found_q      <= 1'b0;
      pick_q       <= '0;
      miss_q       <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      t_q       <= t_d;
      cfg_vld_q <= cfg_vld_d;
      run_vld_q <= run_vld_d;
      found_q   <= found_d;
      pick_q    <= pick_d;
      miss_q    <= miss_d;
      if (cfg_we_i) begin
        task_count_q <= cfg_wdata_i;
      end
      if (fix_done) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_abs_q   <= best_abs_d;
    best_work_q  <= best_work_d;
    best_phase_q <= best_phase_d;
    if (fix_done) begin
      out_time_q <= t32;
      out_idle_q <= !found_q;
      out_miss_q <= miss_q;
      if (found_q) begin
        out_task_q <= TaskIw'(32'(pick_q));
        out_dl_q   <= best_abs_q;
      end else begin
        out_task_q <= '0;
        out_dl_q   <= '0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_idle_q;
  assign m_axis_tdata  = {4'b0, out_miss_q, out_dl_q, out_task_q, out_time_q};

  a_rose_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIX))
    else $error("result appeared without a finished scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CNTW'(MAX_TASKS)))
    else $error("scan counter past last slot");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[67:32] == '0))
    else $error("idle result carries a task or deadline");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fix_done) |-> (t_q == $past(t_next)))
    else $error("time did not advance by one tick");

endmodule

`default_nettype wire
